// ----- sv/cpfr_pkg.sv -----
package cpfr_pkg;

  localparam int BUFFER_COUNT       = 3;
  localparam int MAX_TRANSFER_BYTES = 16384;
  localparam int TRAILER_BYTES      = 8;
  localparam int BIDX_W             = $clog2(BUFFER_COUNT);
  localparam int LEN_W              = 15;
  localparam int QUEUE_DEPTH        = 2;
  localparam int QPTR_W             = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W             = $clog2(QUEUE_DEPTH + 1);

  localparam logic [15:0] RESET_SIGNATURE   = 16'hA53C;
  localparam logic [15:0] RESET_LAST_PACKET = 16'h02EE;
  localparam logic [23:0] RESET_CAPACITY    = 24'(3000 * 4096 * 1);

  localparam logic [1:0] STATUS_COMPLETED = 2'd0;

  localparam logic [1:0] REG_MAGIC    = 2'd0;
  localparam logic [1:0] REG_LAST     = 2'd1;
  localparam logic [1:0] REG_CAPACITY = 2'd2;

  typedef struct packed {
    logic [1:0]       transfer_status;
    logic [LEN_W-1:0] transfer_length;
    logic [15:0]      packet_number;
    logic [15:0]      signature;
    logic [15:0]      hosting_frame;
  } in_t;

  typedef struct packed {
    logic        payload_write;
    logic [23:0] payload_offset;
    logic [1:0]  payload_buffer;
    logic        sequence_error;
    logic        in_sync;
    logic        frame_done;
    logic        ready_valid;
    logic [1:0]  ready_buffer;
    logic [15:0] ready_frame_number;
  } out_t;

  typedef struct packed {
    logic [15:0] magic_signature;
    logic [15:0] last_packet_number;
    logic [23:0] frame_capacity;
  } cfg_t;

  typedef struct packed {
    logic             active;
    logic             check_fail;
    logic [LEN_W-1:0] plen;
    logic [15:0]      packet_number;
    logic [15:0]      hosting_frame;
  } cls_t;

endpackage

// ----- sv/cpfr_front.sv -----
module cpfr_front import cpfr_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic f_valid,
  output cls_t f_data,
  input  logic q_full
);

  logic [LEN_W-1:0] len_clamped;
  cls_t             cls;

  always_comb begin
    if (32'(in_data.transfer_length) > 32'(MAX_TRANSFER_BYTES)) begin
      len_clamped = LEN_W'(MAX_TRANSFER_BYTES);
    end else begin
      len_clamped = in_data.transfer_length;
    end
    cls.active        = (in_data.transfer_status == STATUS_COMPLETED);
    cls.check_fail    = (len_clamped < LEN_W'(TRAILER_BYTES)) ||
                        (in_data.signature != cfg.magic_signature);
    cls.plen          = len_clamped - LEN_W'(TRAILER_BYTES);
    cls.packet_number = in_data.packet_number;
    cls.hosting_frame = in_data.hosting_frame;
  end

  assign in_stall = f_valid && q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      f_valid <= 1'b1;
    end else if (!q_full) begin
      f_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      f_data <= cls;
    end
  end

endmodule

// ----- sv/cpfr_queue.sv -----
module cpfr_queue import cpfr_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cls_t push_data,
  output logic full,
  output logic q_valid,
  output cls_t q_data,
  input  logic pop
);

  cls_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign full    = (count == QCNT_W'(QUEUE_DEPTH));
  assign q_valid = (count != '0);
  assign q_data  = mem[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

// ----- sv/cpfr_back.sv -----
module cpfr_back import cpfr_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  logic q_valid,
  input  cls_t q_data,
  output logic pop,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  logic [15:0]       expected_packet, expected_packet_next;
  logic              out_of_sync, out_of_sync_next;
  logic [23:0]       write_offset, write_offset_next;
  logic [BIDX_W-1:0] current_buffer, current_buffer_next;
  logic              have_ready, have_ready_next;
  logic [BIDX_W-1:0] ready_index, ready_index_next;
  logic [15:0]       stored_frame_numbers [BUFFER_COUNT];
  logic              done;
  logic [24:0]       sum;
  out_t              res;

  assign pop = q_valid && (!out_valid || !out_stall);

  always_comb begin
    expected_packet_next = expected_packet;
    out_of_sync_next     = out_of_sync;
    write_offset_next    = write_offset;
    current_buffer_next  = current_buffer;
    have_ready_next      = have_ready;
    ready_index_next     = ready_index;
    done                 = 1'b0;
    sum                  = {1'b0, write_offset} + 25'(q_data.plen);
    res                  = '0;
    if (q_data.active) begin
      if (q_data.check_fail || (q_data.packet_number != expected_packet)) begin
        out_of_sync_next     = 1'b1;
        expected_packet_next = '0;
        write_offset_next    = '0;
        res.sequence_error   = 1'b1;
      end else begin
        out_of_sync_next = out_of_sync && (q_data.packet_number != '0);
        if (!out_of_sync_next) begin
          if (sum <= {1'b0, cfg.frame_capacity}) begin
            res.payload_write  = 1'b1;
            res.payload_offset = write_offset;
            res.payload_buffer = 2'(current_buffer);
            write_offset_next  = sum[23:0];
          end
          if (q_data.packet_number >= cfg.last_packet_number) begin
            done                 = 1'b1;
            ready_index_next     = current_buffer;
            have_ready_next      = 1'b1;
            current_buffer_next  = (current_buffer == BIDX_W'(BUFFER_COUNT - 1)) ?
                                   '0 : current_buffer + 1'b1;
            write_offset_next    = '0;
            expected_packet_next = '0;
          end else begin
            expected_packet_next = expected_packet + 16'd1;
          end
        end
      end
    end
    res.in_sync     = !out_of_sync_next;
    res.frame_done  = done;
    res.ready_valid = have_ready_next;
    if (have_ready_next) begin
      res.ready_buffer       = 2'(ready_index_next);
      res.ready_frame_number = done ? q_data.hosting_frame
                                    : stored_frame_numbers[ready_index];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_packet <= '0;
      out_of_sync     <= 1'b0;
      write_offset    <= '0;
      current_buffer  <= '0;
      have_ready      <= 1'b0;
      ready_index     <= '0;
      out_valid       <= 1'b0;
      for (int i = 0; i < BUFFER_COUNT; i++) begin
        stored_frame_numbers[i] <= '0;
      end
    end else begin
      if (pop) begin
        expected_packet <= expected_packet_next;
        out_of_sync     <= out_of_sync_next;
        write_offset    <= write_offset_next;
        current_buffer  <= current_buffer_next;
        have_ready      <= have_ready_next;
        ready_index     <= ready_index_next;
        if (done) begin
          stored_frame_numbers[current_buffer] <= q_data.hosting_frame;
        end
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data <= res;
    end
  end

  a_done_in_sync: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.frame_done |-> out_data.in_sync && !out_data.sequence_error)
    else $error("frame done without sync");

  a_write_in_sync: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.payload_write |-> out_data.in_sync && !out_data.sequence_error)
    else $error("payload write while out of sync");

  a_done_ready: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.frame_done |->
      out_data.ready_valid && out_data.ready_frame_number == stored_frame_numbers[ready_index])
    else $error("completed frame not reported ready");

  a_error_rewinds: assert property (@(posedge clk) disable iff (rst)
    pop && res.sequence_error |=> expected_packet == '0 && write_offset == '0 && out_of_sync)
    else $error("sequence error did not rewind");

endmodule

// ----- sv/camera_packet_frame_reassembler.sv -----
// path: an accepted word passes the front register, a queue entry and the back end's output register
// throughput: one word per cycle while no stall holds the flow; the back end's offset add and compare sets the cycle
// a two-entry queue between front and back lets each side stall on its own
// reset: synchronous active-high rst clears sync state, buffers, queue and handshakes
// registers return to their reset values; no clearing pass is needed
module camera_packet_frame_reassembler import cpfr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_t        out_data
);

  cfg_t cfg;
  logic f_valid;
  cls_t f_data;
  logic q_full;
  logic q_valid;
  cls_t q_data;
  logic pop;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.magic_signature    <= RESET_SIGNATURE;
      cfg.last_packet_number <= RESET_LAST_PACKET;
      cfg.frame_capacity     <= RESET_CAPACITY;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[3:2])
        REG_MAGIC:    cfg.magic_signature    <= pwdata[15:0];
        REG_LAST:     cfg.last_packet_number <= pwdata[15:0];
        REG_CAPACITY: cfg.frame_capacity     <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_MAGIC:    prdata = {16'd0, cfg.magic_signature};
      REG_LAST:     prdata = {16'd0, cfg.last_packet_number};
      REG_CAPACITY: prdata = {8'd0, cfg.frame_capacity};
      default:      prdata = '0;
    endcase
  end

  cpfr_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .f_valid  (f_valid),
    .f_data   (f_data),
    .q_full   (q_full)
  );

  cpfr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (f_valid),
    .push_data (f_data),
    .full      (q_full),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .pop       (pop)
  );

  cpfr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
